@@ hw/rtl/hyt_pkg.sv @@
// hyt_pkg: constants and the arctangent table of the heading tracker
// no dependencies; compiled first
`default_nettype none

package hyt_pkg;

   // angle constants in Q3.12 radians, 18-bit signed working width
   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] NEG_PI_Q12 = -18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

   // microsecond scaling
   localparam logic [19:0] ONE_E6  = 20'd1000000;
   localparam logic [31:0] HALF_E6 = 32'd500000;

   // floor(2^50 / 1e6), quotient is at most one short
   localparam logic [30:0] RECIP_E6    = 31'd1125899906;
   localparam int          RECIP_SHIFT = 50;

   // register reset values
   localparam logic [14:0] MAX_RATE_RESET = 15'd12868;
   localparam logic [30:0] MIN_DIST_RESET = 31'd6554;

   // register indexes
   localparam logic CSR_MAX_RATE     = 1'b0;
   localparam logic CSR_MIN_DISTANCE = 1'b1;

   // cordic datapath sizes
   localparam int CORDIC_ITERS = 20;
   localparam int CORDIC_W     = 45;
   localparam int NORM_W       = 41;
   localparam int ZACC_W       = 22;

   // atan(2^-i) in Q.20 radians
   function automatic logic [19:0] cordic_angle(input logic [4:0] idx);
      logic [19:0] ang;
      case (idx)
         5'd0:    ang = 20'd823550;
         5'd1:    ang = 20'd486170;
         5'd2:    ang = 20'd256879;
         5'd3:    ang = 20'd130396;
         5'd4:    ang = 20'd65451;
         5'd5:    ang = 20'd32757;
         5'd6:    ang = 20'd16383;
         5'd7:    ang = 20'd8192;
         5'd8:    ang = 20'd4096;
         5'd9:    ang = 20'd2048;
         5'd10:   ang = 20'd1024;
         5'd11:   ang = 20'd512;
         5'd12:   ang = 20'd256;
         5'd13:   ang = 20'd128;
         5'd14:   ang = 20'd64;
         5'd15:   ang = 20'd32;
         5'd16:   ang = 20'd16;
         5'd17:   ang = 20'd8;
         5'd18:   ang = 20'd4;
         5'd19:   ang = 20'd2;
         default: ang = 20'd0;
      endcase
      return ang;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hyt_req_if.sv @@
// hyt_req_if: request channel of the heading tracker, valid/ready with one word
// no dependencies
`default_nettype none

interface hyt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic        [15:0] elapsed_us;

   modport source (output valid, output dir_x, output dir_y, output dir_z,
                   output elapsed_us, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                   input elapsed_us, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hyt_rsp_if.sv @@
// hyt_rsp_if: response channel of the heading tracker, valid/ready with one word
// no dependencies
`default_nettype none

interface hyt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_out;
   logic signed [15:0] yaw_rate_out;

   modport source (output valid, output yaw_out, output yaw_rate_out, input ready);
   modport sink   (input valid, input yaw_out, input yaw_rate_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hyt_cordic.sv @@
// hyt_cordic: iterative atan2 in Q3.12 radians (normalize, 20 vectoring steps, round)
// depends on hyt_pkg
`default_nettype none

module hyt_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] x_in,
   input  wire logic signed [31:0] y_in,
   output logic                    busy,
   output logic signed [15:0]      angle
);
   import hyt_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_NORM  = 2'd1;
   localparam logic [1:0] PH_ITER  = 2'd2;
   localparam logic [1:0] PH_ROUND = 2'd3;

   localparam logic [4:0] LAST_ITER = 5'(CORDIC_ITERS - 1);
   localparam logic [4:0] LAST_NORM = 5'd5;
   localparam logic [5:0] NORM_TOP  = 6'(NORM_W);

   logic [1:0]                 phase_ff, phase_in;
   logic [4:0]                 step_ff, step_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic [NORM_W-1:0]          m_ff, m_in;
   logic signed [ZACC_W-1:0]   z_ff, z_in;
   logic signed [17:0]         base_ff, base_in;
   logic signed [15:0]         angle_ff, angle_in;

   logic signed [CORDIC_W-1:0] xe, ye, dx, dy;
   logic [31:0]                ax, ay;
   logic [5:0]                 norm_sh;
   logic signed [ZACC_W-1:0]   ang_s, z_rnd;
   logic signed [17:0]         v;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      x_in_nx  = x_ff;
      y_in_nx  = y_ff;
      m_in     = m_ff;
      z_in     = z_ff;
      base_in  = base_ff;
      angle_in = angle_ff;

      // operand fold into the right half plane
      xe = CORDIC_W'(x_in);
      ye = CORDIC_W'(y_in);
      ax = x_in[31] ? 32'(-x_in) : 32'(x_in);
      ay = y_in[31] ? 32'(-y_in) : 32'(y_in);

      norm_sh = 6'(6'd32 >> step_ff[2:0]);
      dx      = x_ff >>> step_ff;
      dy      = y_ff >>> step_ff;
      ang_s   = $signed({2'b00, cordic_angle(step_ff)});
      z_rnd   = z_ff + 22'sd128;
      v       = base_ff + 18'(z_rnd >>> 8);

      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               x_in_nx = x_in[31] ? -xe : xe;
               y_in_nx = x_in[31] ? -ye : ye;
               base_in = x_in[31] ? (y_in[31] ? NEG_PI_Q12 : PI_Q12) : 18'sd0;
               m_in    = NORM_W'((ax > ay) ? ax : ay);
               z_in    = '0;
               step_in = '0;
               // a zero vector goes straight to rounding and gives zero
               phase_in = (x_in == '0 && y_in == '0) ? PH_ROUND : PH_NORM;
            end
         end
         PH_NORM: begin
            // binary search for the shift that puts the top bit at bit 40
            if ((m_ff >> (NORM_TOP - norm_sh)) == '0) begin
               x_in_nx = x_ff <<< norm_sh;
               y_in_nx = y_ff <<< norm_sh;
               m_in    = m_ff << norm_sh;
            end
            if (step_ff == LAST_NORM) begin
               step_in  = '0;
               phase_in = PH_ITER;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         PH_ITER: begin
            // one vectoring rotation per cycle
            if (!y_ff[CORDIC_W-1]) begin
               x_in_nx = x_ff + dy;
               y_in_nx = y_ff - dx;
               z_in    = z_ff + ang_s;
            end else begin
               x_in_nx = x_ff - dy;
               y_in_nx = y_ff + dx;
               z_in    = z_ff - ang_s;
            end
            if (step_ff == LAST_ITER) begin
               phase_in = PH_ROUND;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         PH_ROUND: begin
            // round half up to Q3.12, add the half-plane base, clamp to +-pi
            if (v > PI_Q12) begin
               angle_in = 16'(PI_Q12);
            end else if (v < NEG_PI_Q12) begin
               angle_in = 16'(NEG_PI_Q12);
            end else begin
               angle_in = 16'(v);
            end
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff     <= x_in_nx;
      y_ff     <= y_in_nx;
      m_ff     <= m_in;
      z_ff     <= z_in;
      base_ff  <= base_in;
      angle_ff <= angle_in;
   end

   assign busy  = (phase_ff != PH_IDLE);
   assign angle = angle_ff;

endmodule

`default_nettype wire

@@ hw/rtl/yaw_rate_limited_heading_tracker.sv @@
// yaw_rate_limited_heading_tracker: rate-limited yaw command from a look-ahead vector
// depends on hyt_pkg, hyt_req_if, hyt_rsp_if and hyt_cordic
//
// usage:
//   req_chan takes one word per step: direction vector (Q16.16 m) and the time
//   since the previous step in microseconds. rsp_chan returns one word per
//   request: the commanded yaw and the filtered yaw rate, both Q3.12.
//   csr_we/csr_index/csr_wdata write max_rate (index 0) and min_distance
//   (index 1); write them only while the block is idle.
// timing:
//   req_chan.ready is high only while idle; one request is in work at a time.
//   a request runs through the prep, wait, difference and limit states; when the rate
//   is clamped or wrapped it goes on to the final state, and when the rate comes from
//   the difference it passes the dividend load, the 32-step radix-2 divider and
//   the saturation state first. a shared 32x32 multiplier, one product a cycle, runs the
//   length test and the step limit while the atan2 unit works.
// stall and reset:
//   the response sits in an output register; the next request is accepted
//   while it waits, and its own result holds in the final state until the
//   register frees. reset clears the previous yaw and rate to zero and loads
//   the register defaults (pi rad/s, 0.1 m).
`default_nettype none

module yaw_rate_limited_heading_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   hyt_req_if.sink          req_chan,
   hyt_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);
   import hyt_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PREP  = 4'd1;
   localparam logic [3:0] ST_WAIT  = 4'd2;
   localparam logic [3:0] ST_DIFF  = 4'd3;
   localparam logic [3:0] ST_LIMIT = 4'd4;
   localparam logic [3:0] ST_DLOAD = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_SAT   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   localparam logic [3:0] PREP_LAST = 4'd9;
   localparam logic [4:0] DIV_LAST  = 5'd31;

   // bring an angle back into +-pi
   function automatic logic signed [17:0] wrap_pi(input logic signed [17:0] a);
      logic signed [17:0] r;
      if (a < NEG_PI_Q12) begin
         r = a + TWO_PI_Q12;
      end else if (a > PI_Q12) begin
         r = a - TWO_PI_Q12;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // registers
   logic [14:0]        max_rate_ff, max_rate_in;
   logic [30:0]        min_dist_ff, min_dist_in;
   logic [3:0]         state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [15:0]        el_ff, el_in;
   logic [63:0]        prod_ff;
   logic signed [64:0] acc_ff, acc_in;
   logic               long_ff, long_in;
   logic [31:0]        n_ff, n_in;
   logic [11:0]        q0_ff, q0_in;
   logic [11:0]        mc_ff, mc_in;
   logic signed [17:0] yt_ff, yt_in, d_ff, d_in, yaw_ff, yaw_in;
   logic signed [16:0] rate_ff, rate_in;
   logic               neg_ff, neg_in;
   logic [15:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic signed [15:0] prev_yaw_ff, prev_yaw_in, prev_rate_ff, prev_rate_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_yaw_ff, rsp_yaw_in, rsp_rate_ff, rsp_rate_in;

   // combinational helpers
   logic               req_fire, fin_go;
   logic               cordic_busy;
   logic signed [15:0] cordic_angle_q;
   logic [31:0]        mul_a, mul_b;
   logic signed [17:0] ly, mc_s, lo_yaw, hi_yaw, d_abs, diff, diff_abs, yaw_fin;
   logic signed [16:0] mr_s;
   logic signed [17:0] rate_sum;
   logic [32:0]        mc_rem;
   logic [16:0]        div_shift;
   logic               div_ge;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign fin_go   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   // atan2 unit starts on every accepted word
   hyt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .x_in  (req_chan.dir_x),
      .y_in  (req_chan.dir_y),
      .busy  (cordic_busy),
      .angle (cordic_angle_q)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_PREP) begin
         case (cnt_ff)
            4'd0: begin
               mul_a = {1'b0, min_dist_ff};
               mul_b = {1'b0, min_dist_ff};
            end
            4'd1: begin
               mul_a = ax_ff;
               mul_b = ax_ff;
            end
            4'd2: begin
               mul_a = ay_ff;
               mul_b = ay_ff;
            end
            4'd3: begin
               mul_a = az_ff;
               mul_b = az_ff;
            end
            4'd4: begin
               mul_a = {17'd0, max_rate_ff};
               mul_b = {16'd0, el_ff};
            end
            4'd6: begin
               mul_a = n_ff;
               mul_b = {1'b0, RECIP_E6};
            end
            4'd8: begin
               mul_a = {20'd0, q0_ff};
               mul_b = {12'd0, ONE_E6};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == ST_LIMIT) begin
         mul_a = 32'(unsigned'(d_abs));
         mul_b = {12'd0, ONE_E6};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer and datapath next values
   always_comb begin
      max_rate_in  = max_rate_ff;
      min_dist_in  = min_dist_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      div_cnt_in   = div_cnt_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      el_in        = el_ff;
      acc_in       = acc_ff;
      long_in      = long_ff;
      n_in         = n_ff;
      q0_in        = q0_ff;
      mc_in        = mc_ff;
      yt_in        = yt_ff;
      d_in         = d_ff;
      yaw_in       = yaw_ff;
      rate_in      = rate_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prev_yaw_in  = prev_yaw_ff;
      prev_rate_in = prev_rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_rate_in  = rsp_rate_ff;

      ly       = 18'(prev_yaw_ff);
      mc_s     = $signed({6'd0, mc_ff});
      mr_s     = $signed({2'b00, max_rate_ff});
      lo_yaw   = wrap_pi(ly - mc_s);
      hi_yaw   = wrap_pi(ly + mc_s);
      d_abs    = d_ff[17] ? -d_ff : d_ff;
      diff     = yaw_ff - ly;
      diff_abs = diff[17] ? -diff : diff;
      yaw_fin  = (diff_abs <= mc_s) ? ((ly + yaw_ff) >>> 1) : yaw_ff;
      rate_sum = 18'(prev_rate_ff) + 18'(rate_ff);
      mc_rem   = {1'b0, n_ff} - {1'b0, prod_ff[31:0]};

      div_shift = {rem_ff, quo_ff[31]};
      div_ge    = (div_shift >= {1'b0, el_ff});

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_RATE:     max_rate_in = csr_wdata[14:0];
            CSR_MIN_DISTANCE: min_dist_in = csr_wdata;
            default:          max_rate_in = max_rate_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ax_in    = req_chan.dir_x[31] ? 32'(-req_chan.dir_x) : 32'(req_chan.dir_x);
               ay_in    = req_chan.dir_y[31] ? 32'(-req_chan.dir_y) : 32'(req_chan.dir_y);
               az_in    = req_chan.dir_z[31] ? 32'(-req_chan.dir_z) : 32'(req_chan.dir_z);
               el_in    = (req_chan.elapsed_us == '0) ? 16'd1 : req_chan.elapsed_us;
               cnt_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // length test against min_distance^2, then the step limit
            case (cnt_ff)
               4'd1:    acc_in = -$signed({1'b0, prod_ff});
               4'd2:    acc_in = acc_ff + $signed({1'b0, prod_ff});
               4'd3:    acc_in = acc_ff + $signed({1'b0, prod_ff});
               4'd4:    acc_in = acc_ff + $signed({1'b0, prod_ff});
               4'd5: begin
                  long_in = !acc_ff[64] && (acc_ff != '0);
                  n_in    = prod_ff[31:0] + HALF_E6;
               end
               4'd7:    q0_in = prod_ff[RECIP_SHIFT+11:RECIP_SHIFT];
               4'd9: begin
                  mc_in = (mc_rem >= {13'd0, ONE_E6}) ? q0_ff + 12'd1 : q0_ff;
               end
               default: acc_in = acc_ff;
            endcase
            if (cnt_ff == PREP_LAST) begin
               state_in = ST_WAIT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_WAIT: begin
            if (!cordic_busy) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // target yaw and its difference from the last yaw
            yt_in    = long_ff ? 18'(cordic_angle_q) : ly;
            d_in     = (long_ff ? 18'(cordic_angle_q) : ly) - ly;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            // short way across the wrap, clamp to the step limit
            neg_in   = d_ff[17];
            state_in = ST_FIN;
            if (d_ff > PI_Q12) begin
               yaw_in  = (d_ff - TWO_PI_Q12 < -mc_s) ? lo_yaw : yt_ff;
               rate_in = -mr_s;
            end else if (d_ff < NEG_PI_Q12) begin
               yaw_in  = (d_ff + TWO_PI_Q12 > mc_s) ? hi_yaw : yt_ff;
               rate_in = mr_s;
            end else if (d_ff < -mc_s) begin
               yaw_in  = lo_yaw;
               rate_in = -mr_s;
            end else if (d_ff > mc_s) begin
               yaw_in  = hi_yaw;
               rate_in = mr_s;
            end else begin
               yaw_in   = yt_ff;
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            // dividend |d| * 1e6 + el / 2
            rem_in     = '0;
            quo_in     = prod_ff[31:0] + {17'd0, el_ff[15:1]};
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide by elapsed time, one quotient bit per cycle
            rem_in = div_ge ? 16'(div_shift - {1'b0, el_ff}) : div_shift[15:0];
            quo_in = {quo_ff[30:0], div_ge};
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end else begin
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         ST_SAT: begin
            // signed rate with saturation
            if (neg_ff) begin
               rate_in = (|quo_ff[31:15]) ? -17'sd32768 : -$signed({1'b0, quo_ff[15:0]});
            end else begin
               rate_in = ((|quo_ff[31:15]) || (&quo_ff[14:0])) ? 17'sd32767
                                                               : $signed({1'b0, quo_ff[15:0]});
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // smoothing and result word, held while the output slot is full
            if (fin_go) begin
               prev_yaw_in  = 16'(yaw_fin);
               prev_rate_in = 16'(rate_sum >>> 1);
               rsp_yaw_in   = 16'(yaw_fin);
               rsp_rate_in  = 16'(rate_sum >>> 1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff  <= MAX_RATE_RESET;
         min_dist_ff  <= MIN_DIST_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         div_cnt_ff   <= '0;
         prev_yaw_ff  <= '0;
         prev_rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_rate_ff  <= max_rate_in;
         min_dist_ff  <= min_dist_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         div_cnt_ff   <= div_cnt_in;
         prev_yaw_ff  <= prev_yaw_in;
         prev_rate_ff <= prev_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      el_ff       <= el_in;
      acc_ff      <= acc_in;
      long_ff     <= long_in;
      n_ff        <= n_in;
      q0_ff       <= q0_in;
      mc_ff       <= mc_in;
      yt_ff       <= yt_in;
      d_ff        <= d_in;
      yaw_ff      <= yaw_in;
      rate_ff     <= rate_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_yaw_ff  <= rsp_yaw_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.yaw_out      = rsp_yaw_ff;
   assign rsp_chan.yaw_rate_out = rsp_rate_ff;

`ifndef ASSERT_OFF
   // a new word never lands on a running atan2
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !cordic_busy)
      else $error("word accepted while atan2 unit busy");

   // stored yaw stays within +-pi
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (prev_yaw_ff <= 16'sd12868) && (prev_yaw_ff >= -16'sd12868))
      else $error("stored yaw out of range");

   // step limit never exceeds its bound
   a_mc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (mc_ff <= 12'd2148))
      else $error("step limit out of range");

   // a finished word is not dropped on a full output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("response word lost");
`endif

endmodule

`default_nettype wire
